FILE: rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies; used by every other file in rtl/.
`default_nettype none

package mhpq_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_WIDTH    = 32;  // width of value fields on the ports
   localparam int TOTAL_WIDTH    = 7;   // width of the entry count field

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_ADD    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // what every cell of the chain does in a given cycle
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT_UP,
      OP_DROP_TAIL
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REINSERT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/mhpq_cell.sv
// One cell of the sorted chain: holds one entry, its valid bit and a tail copy.
// Depends on mhpq_pkg.
`default_nettype none

module mhpq_cell #(
   parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  mhpq_pkg::cell_op_type        op,
   input  wire logic signed [DATA_WIDTH-1:0] ins_value,
   input  wire                          prev_take,
   input  wire logic signed [DATA_WIDTH-1:0] prev_val,
   input  wire                          prev_valid,
   input  wire logic signed [DATA_WIDTH-1:0] next_val,
   input  wire                          next_valid,
   input  wire logic signed [DATA_WIDTH-1:0] next_tail,
   output logic signed [DATA_WIDTH-1:0] val,
   output logic                         valid,
   output logic                         take,
   output logic signed [DATA_WIDTH-1:0] tail
);

   logic signed [DATA_WIDTH-1:0] val_ff, val_in;
   logic signed [DATA_WIDTH-1:0] tail_ff, tail_in;
   logic                         valid_ff, valid_in;

   // new value goes here or above: equal entries keep their place
   assign take = !valid_ff || (ins_value > val_ff);

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      // last valid value, carried one cell toward the head each cycle
      tail_in  = next_valid ? next_tail : val_ff;
      case (op)
         mhpq_pkg::OP_INSERT: begin
            if (take) begin
               val_in   = prev_take ? prev_val : ins_value;
               valid_in = prev_take ? prev_valid : 1'b1;
            end
         end
         mhpq_pkg::OP_SHIFT_UP: begin
            val_in   = next_val;
            valid_in = next_valid;
         end
         mhpq_pkg::OP_DROP_TAIL: begin
            valid_in = valid_ff && next_valid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff  <= val_in;
      tail_ff <= tail_in;
   end

   assign val   = val_ff;
   assign valid = valid_ff;
   assign tail  = tail_ff;

endmodule

`default_nettype wire

FILE: rtl/mhpq_ctrl.sv
// Request sequencer: entry count, status, tail wait and response strobe.
// Depends on mhpq_pkg; drives the cell chain built in the top level.
`default_nettype none

module mhpq_ctrl #(
   parameter int CAPACITY   = mhpq_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire logic [1:0]                   mode,
   input  wire logic signed [DATA_WIDTH-1:0] value,
   input  wire logic signed [DATA_WIDTH-1:0] head_val,
   input  wire logic signed [DATA_WIDTH-1:0] tail_val,
   output logic                              busy,
   output mhpq_pkg::cell_op_type             op,
   output logic signed [DATA_WIDTH-1:0]      ins_value,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [mhpq_pkg::FIELD_WIDTH-1:0] rsp_removed_value,
   output logic signed [mhpq_pkg::FIELD_WIDTH-1:0] rsp_top_value,
   output logic [mhpq_pkg::TOTAL_WIDTH-1:0]  rsp_entry_total
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   mhpq_pkg::state_type          state_ff, state_in;
   mhpq_pkg::status_type         status_ff, status_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [CNT_W-1:0]             wait_ff, wait_in;
   logic signed [DATA_WIDTH-1:0] removed_ff, removed_in;
   logic signed [DATA_WIDTH-1:0] arg_ff, arg_in;
   logic                         accept;

   assign accept = (state_ff == mhpq_pkg::ST_IDLE) && start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhpq_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      status_ff  <= status_in;
      wait_ff    <= wait_in;
      removed_ff <= removed_in;
      arg_ff     <= arg_in;
   end

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cnt_in     = cnt_ff;
      wait_in    = wait_ff;
      removed_in = removed_ff;
      arg_in     = arg_ff;
      op         = mhpq_pkg::OP_HOLD;
      ins_value  = (state_ff == mhpq_pkg::ST_IDLE) ? value : arg_ff;
      rsp_valid  = 1'b0;
      case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (start) begin
               status_in  = mhpq_pkg::STATUS_OK;
               removed_in = '0;
               state_in   = mhpq_pkg::ST_RESP;
               case (mhpq_pkg::mode_type'(mode))
                  mhpq_pkg::MODE_INSERT: begin
                     if (cnt_ff == CNT_W'(CAPACITY)) begin
                        status_in = mhpq_pkg::STATUS_FULL;
                     end else begin
                        op     = mhpq_pkg::OP_INSERT;
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  mhpq_pkg::MODE_DELETE: begin
                     if (cnt_ff == '0) begin
                        status_in = mhpq_pkg::STATUS_EMPTY;
                     end else begin
                        op         = mhpq_pkg::OP_SHIFT_UP;
                        removed_in = head_val;
                        cnt_in     = cnt_ff - CNT_W'(1);
                     end
                  end
                  mhpq_pkg::MODE_ADD: begin
                     if (cnt_ff == '0) begin
                        status_in = mhpq_pkg::STATUS_EMPTY;
                     end else begin
                        arg_in   = value;
                        wait_in  = '0;
                        state_in = mhpq_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mhpq_pkg::ST_SCAN: begin
            // tail copy at the head is settled once it crossed every entry
            wait_in = wait_ff + CNT_W'(1);
            if (wait_ff == cnt_ff - CNT_W'(1)) begin
               op       = mhpq_pkg::OP_DROP_TAIL;
               arg_in   = tail_val + arg_ff;
               state_in = mhpq_pkg::ST_REINSERT;
            end
         end
         mhpq_pkg::ST_REINSERT: begin
            op       = mhpq_pkg::OP_INSERT;
            state_in = mhpq_pkg::ST_RESP;
         end
         mhpq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = mhpq_pkg::ST_IDLE;
         end
         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != mhpq_pkg::ST_IDLE);
   assign rsp_status        = status_ff;
   assign rsp_removed_value = mhpq_pkg::FIELD_WIDTH'(removed_ff);
   assign rsp_top_value     = (cnt_ff != '0) ? mhpq_pkg::FIELD_WIDTH'(head_val) : '0;
   assign rsp_entry_total   = mhpq_pkg::TOTAL_WIDTH'(cnt_ff);

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == mhpq_pkg::MODE_INSERT && cnt_ff == CNT_W'(CAPACITY))
      |=> (status_ff == mhpq_pkg::STATUS_FULL && $stable(cnt_ff)))
      else $error("insert on full queue changed the count");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == mhpq_pkg::MODE_DELETE && cnt_ff != '0)
      |=> (cnt_ff == $past(cnt_ff) - CNT_W'(1)))
      else $error("delete did not decrement the count");

   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mhpq_pkg::ST_SCAN || state_ff == mhpq_pkg::ST_REINSERT)
      |=> $stable(cnt_ff))
      else $error("count moved during add");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

FILE: rtl/max_heap_priority_queue.sv
// Top level of the max priority queue: cell chain plus request sequencer.
// Depends on mhpq_pkg, mhpq_cell and mhpq_ctrl.
`default_nettype none

// Priority queue of signed values, up to CAPACITY entries. An item is taken
// when start is high and busy is low; busy then stays high until the
// response. The response is on the rsp_ ports for exactly one cycle, marked
// by rsp_valid, and cannot be held off. Entries live in a row of cells kept
// in descending order, so the maximum always sits in the first cell.
// Insert and delete-maximum move the whole row by one step at once and go
// from accept straight to the response state. Add-to-minimum waits for the
// copy of the last entry, passed one cell per cycle toward the head, then
// drops that entry and re-inserts the sum. Another item can be started in
// the cycle after the response. Full and empty requests report their status
// and change nothing.
module max_heap_priority_queue #(
   parameter int CAPACITY   = mhpq_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire logic [1:0]                    req_mode,
   input  wire logic signed [mhpq_pkg::FIELD_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic signed [mhpq_pkg::FIELD_WIDTH-1:0] rsp_removed_value,
   output logic signed [mhpq_pkg::FIELD_WIDTH-1:0] rsp_top_value,
   output logic [mhpq_pkg::TOTAL_WIDTH-1:0]   rsp_entry_total
);

   mhpq_pkg::cell_op_type        op;
   logic signed [DATA_WIDTH-1:0] ins_value;
   logic signed [DATA_WIDTH-1:0] req_value_dw;

   // per-cell outputs; index 0 holds the maximum
   logic signed [DATA_WIDTH-1:0] cell_val  [CAPACITY];
   logic signed [DATA_WIDTH-1:0] cell_tail [CAPACITY];
   logic [CAPACITY-1:0]          cell_valid;
   logic [CAPACITY-1:0]          cell_take;

   // port value to internal width: sign-extended or truncated
   assign req_value_dw = DATA_WIDTH'(req_value);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                         prev_take;
         logic signed [DATA_WIDTH-1:0] prev_val;
         logic                         prev_valid;
         logic signed [DATA_WIDTH-1:0] next_val;
         logic                         next_valid;
         logic signed [DATA_WIDTH-1:0] next_tail;

         if (gi == 0) begin : g_head
            assign prev_take  = 1'b0;
            assign prev_val   = '0;
            assign prev_valid = 1'b0;
         end else begin : g_mid
            assign prev_take  = cell_take[gi-1];
            assign prev_val   = cell_val[gi-1];
            assign prev_valid = cell_valid[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign next_val   = '0;
            assign next_valid = 1'b0;
            assign next_tail  = '0;
         end else begin : g_body
            assign next_val   = cell_val[gi+1];
            assign next_valid = cell_valid[gi+1];
            assign next_tail  = cell_tail[gi+1];
         end

         mhpq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .op         (op),
            .ins_value  (ins_value),
            .prev_take  (prev_take),
            .prev_val   (prev_val),
            .prev_valid (prev_valid),
            .next_val   (next_val),
            .next_valid (next_valid),
            .next_tail  (next_tail),
            .val        (cell_val[gi]),
            .valid      (cell_valid[gi]),
            .take       (cell_take[gi]),
            .tail       (cell_tail[gi])
         );
      end
   endgenerate

   mhpq_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .mode              (req_mode),
      .value             (req_value_dw),
      .head_val          (cell_val[0]),
      .tail_val          (cell_tail[0]),
      .busy              (busy),
      .op                (op),
      .ins_value         (ins_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_top_value     (rsp_top_value),
      .rsp_entry_total   (rsp_entry_total)
   );

`ifndef SYNTHESIS
   // valid cells always form an unbroken run from the head
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
      else $error("hole in the cell chain");

   // while idle, the head is never below its neighbor
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (!busy && cell_valid[0] && cell_valid[CAPACITY > 1 ? 1 : 0])
      |-> (cell_val[0] >= cell_val[CAPACITY > 1 ? 1 : 0]))
      else $error("chain out of order at the head");

   // idle count matches the valid cells
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (!busy && CAPACITY < 128)
      |-> ($countones(cell_valid) == int'(rsp_entry_total)))
      else $error("entry count disagrees with valid cells");
`endif

endmodule

`default_nettype wire

FILE: sim/mhpq_monitor.sv
// Response checker for the max-heap priority queue: tracks the heap contents
// from accepted requests and compares every response. Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_monitor (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic [1:0]                              req_mode,
   input  logic signed [mhpq_pkg::FIELD_WIDTH-1:0] req_value,
   input  logic                                    rsp_valid,
   input  logic [1:0]                              rsp_status,
   input  logic signed [mhpq_pkg::FIELD_WIDTH-1:0] rsp_removed_value,
   input  logic signed [mhpq_pkg::FIELD_WIDTH-1:0] rsp_top_value,
   input  logic [mhpq_pkg::TOTAL_WIDTH-1:0]        rsp_entry_total,
   output int unsigned                             fault_count,
   output int unsigned                             pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      mhpq_pkg::status_type                    status;
      logic signed [mhpq_pkg::FIELD_WIDTH-1:0] removed;
      logic signed [mhpq_pkg::FIELD_WIDTH-1:0] top;
      logic [mhpq_pkg::TOTAL_WIDTH-1:0]        total;
   } heap_rsp_type;

   logic signed [mhpq_pkg::FIELD_WIDTH-1:0] heap_mem [mhpq_pkg::CAPACITY_DEF];
   int unsigned                             heap_len       = 0;
   heap_rsp_type                            expected_rsps [$];
   int unsigned                             mismatch_total = 0;
   int unsigned                             rsp_index      = 0;

   task automatic swap_entries(input int unsigned a, input int unsigned b);
      logic signed [mhpq_pkg::FIELD_WIDTH-1:0] tmp;
      tmp         = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = tmp;
   endtask

   // strict compares: equal entries stay put, left child wins a tie
   task automatic sink_entry(input int unsigned idx, input int unsigned n);
      int unsigned l, r, big;
      while (idx < n) begin
         l   = 2 * idx + 1;
         r   = l + 1;
         big = idx;
         if (l < n && heap_mem[big] < heap_mem[l]) big = l;
         if (r < n && heap_mem[big] < heap_mem[r]) big = r;
         if (big == idx) break;
         swap_entries(idx, big);
         idx = big;
      end
   endtask

   task automatic float_entry(input int unsigned idx);
      int unsigned up;
      while (idx > 0) begin
         up = (idx - 1) / 2;
         if (heap_mem[idx] < heap_mem[up]) break;
         swap_entries(idx, up);
         idx = up;
      end
   endtask

   task automatic apply_request(input logic [1:0] mode,
                                input logic signed [mhpq_pkg::FIELD_WIDTH-1:0] value,
                                output heap_rsp_type rsp);
      int unsigned n, low_leaf;
      n           = heap_len;
      rsp.status  = mhpq_pkg::STATUS_OK;
      rsp.removed = '0;
      case (mode)
         mhpq_pkg::MODE_INSERT: begin
            if (n >= mhpq_pkg::CAPACITY_DEF) begin
               rsp.status = mhpq_pkg::STATUS_FULL;
            end else begin
               heap_mem[n] = value;
               heap_len    = n + 1;
               float_entry(n);
            end
         end
         mhpq_pkg::MODE_DELETE: begin
            if (n == 0) begin
               rsp.status = mhpq_pkg::STATUS_EMPTY;
            end else begin
               rsp.removed = heap_mem[0];
               heap_mem[0] = heap_mem[n-1];
               heap_len    = n - 1;
               sink_entry(0, n - 1);
            end
         end
         mhpq_pkg::MODE_ADD: begin
            if (n == 0) begin
               rsp.status = mhpq_pkg::STATUS_EMPTY;
            end else begin
               // minimum lives among the leaves; lowest index wins a tie
               low_leaf = n / 2;
               for (int unsigned i = n / 2; i < n; i++)
                  if (heap_mem[i] < heap_mem[low_leaf]) low_leaf = i;
               heap_mem[low_leaf] = heap_mem[low_leaf] + value;  // wraps
               for (int unsigned i = n / 2; i > 0; i--)
                  sink_entry(i - 1, n);
            end
         end
         default: ;  // unused code: no change
      endcase
      rsp.top   = (heap_len > 0) ? heap_mem[0] : '0;
      rsp.total = heap_len[mhpq_pkg::TOTAL_WIDTH-1:0];
   endtask

   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset) begin
         // a response never belongs to a request taken at the same edge
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= REPORT_LIMIT)
                  $display("%0t: response %0d with none outstanding: status %0d removed %0d "
                           , $time, rsp_index, rsp_status, rsp_removed_value,
                           "top %0d total %0d", rsp_top_value, rsp_entry_total);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status || rsp_removed_value !== want.removed ||
                   rsp_top_value !== want.top || rsp_entry_total !== want.total) begin
                  mismatch_total++;
                  if (mismatch_total <= REPORT_LIMIT) begin
                     $display("%0t: response %0d mismatch", $time, rsp_index);
                     $display("   expected status %0d removed %0d top %0d total %0d",
                              want.status, want.removed, want.top, want.total);
                     $display("   actual   status %0d removed %0d top %0d total %0d",
                              rsp_status, rsp_removed_value, rsp_top_value,
                              rsp_entry_total);
                  end
               end
            end
            rsp_index++;
         end
         if (start && !busy) begin
            apply_request(req_mode, req_value, want);
            expected_rsps.push_back(want);
         end
      end
      fault_count   <= mismatch_total;
      pending_count <= expected_rsps.size();
   end

endmodule

FILE: sim/tb_max_heap_priority_queue.sv
// Testbench top for max_heap_priority_queue: clock, reset, request stimulus,
// watchdog and verdict. Depends on mhpq_pkg, mhpq_monitor and the block.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;

   localparam int          RANDOM_ITEMS = 1325;
   localparam int          IDLE_LIMIT   = 2000;  // covers the slowest op plus the longest gap
   localparam int          DRAIN_CYCLES = mhpq_pkg::CAPACITY_DEF + 8;
   localparam logic [1:0]  MODE_NOP     = 2'd3;  // spare mode code, must be a no-op

   logic                                    clock     = 1'b0;
   logic                                    reset     = 1'b1;
   logic                                    start     = 1'b0;
   logic [1:0]                              req_mode  = mhpq_pkg::MODE_INSERT;
   logic signed [mhpq_pkg::FIELD_WIDTH-1:0] req_value = '0;
   logic                                    busy;
   logic                                    rsp_valid;
   logic [1:0]                              rsp_status;
   logic signed [mhpq_pkg::FIELD_WIDTH-1:0] rsp_removed_value;
   logic signed [mhpq_pkg::FIELD_WIDTH-1:0] rsp_top_value;
   logic [mhpq_pkg::TOTAL_WIDTH-1:0]        rsp_entry_total;
   int unsigned                             fault_count;
   int unsigned                             pending_count;

   // stimulus steering only: rough occupancy, gap bursts
   int                            fill_level = 0;
   int                            burst_left = 0;
   int                            idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   max_heap_priority_queue i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_top_value     (rsp_top_value),
      .rsp_entry_total   (rsp_entry_total)
   );

   mhpq_monitor i_monitor (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_top_value     (rsp_top_value),
      .rsp_entry_total   (rsp_entry_total),
      .fault_count       (fault_count),
      .pending_count     (pending_count)
   );

   // Watchdog: any edge that moves an item or a result counts as progress.
   // Catches a hung busy as well as a response that never shows up.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly short gaps, a few long ones, and now and then a run of
   // back-to-back items with start held high throughout.
   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         burst_left = $urandom_range(50, 20);
         return 0;
      end
      if (roll < 35) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Full range most of the time; small values make ties, extremes hit wrap.
   function automatic logic signed [mhpq_pkg::FIELD_WIDTH-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom;
      if (roll < 85) return $signed($urandom_range(16)) - 8;
      case ($urandom_range(5))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         4:       return 32'sd1;
         default: return 32'sh7fff_fff0;
      endcase
   endfunction

   // Filling phases lean on insert, draining phases on delete; add-to-minimum
   // and the spare code are spread over both.
   function automatic logic [1:0] pick_mode(input bit filling);
      int roll;
      roll = $urandom_range(99);
      if (roll < 5)  return MODE_NOP;
      if (roll < 20) return mhpq_pkg::MODE_ADD;
      if (roll < 35) return filling ? mhpq_pkg::MODE_DELETE : mhpq_pkg::MODE_INSERT;
      return filling ? mhpq_pkg::MODE_INSERT : mhpq_pkg::MODE_DELETE;
   endfunction

   // One item: optional gap with start low, then hold it until busy is low
   // at an edge. Start is left high, so a zero gap gives back-to-back items.
   task automatic issue(input logic [1:0] mode,
                        input logic signed [mhpq_pkg::FIELD_WIDTH-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (busy);
      if (mode == mhpq_pkg::MODE_INSERT && fill_level < mhpq_pkg::CAPACITY_DEF) fill_level++;
      if (mode == mhpq_pkg::MODE_DELETE && fill_level > 0) fill_level--;
   endtask

   initial begin
      bit filling;
      int high_mark;
      int low_mark;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-heap errors, spare code, extremes, ties, wrap both ways
      issue(mhpq_pkg::MODE_DELETE, 32'sd0);
      issue(mhpq_pkg::MODE_ADD, 32'sd5);
      issue(MODE_NOP, -32'sd1);
      issue(mhpq_pkg::MODE_INSERT, 32'sh7fff_ffff);
      issue(mhpq_pkg::MODE_ADD, 32'sh7fff_ffff);      // positive overflow of a single entry
      issue(mhpq_pkg::MODE_INSERT, 32'sh8000_0000);
      issue(mhpq_pkg::MODE_INSERT, 32'sd0);
      issue(mhpq_pkg::MODE_INSERT, -32'sd1);
      issue(mhpq_pkg::MODE_INSERT, 32'sd5);
      issue(mhpq_pkg::MODE_INSERT, 32'sd5);           // tie with an existing entry
      issue(mhpq_pkg::MODE_ADD, 32'sd1);              // bumps the most negative entry
      issue(mhpq_pkg::MODE_ADD, 32'sh8000_0000);      // negative overflow wraps
      issue(MODE_NOP, 32'sh5555_5555);
      repeat (7) issue(mhpq_pkg::MODE_DELETE, 32'sh2aaa_aaaa);  // last one hits empty
      issue(mhpq_pkg::MODE_INSERT, 32'sh5555_5555);
      issue(mhpq_pkg::MODE_INSERT, 32'shaaaa_aaaa);
      issue(mhpq_pkg::MODE_ADD, 32'sh7fff_ffff);
      issue(mhpq_pkg::MODE_DELETE, 32'sd0);
      issue(mhpq_pkg::MODE_DELETE, 32'sd0);

      // random: swing between full and empty so both error cases recur
      filling   = 1'b1;
      high_mark = mhpq_pkg::CAPACITY_DEF;
      low_mark  = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (filling && fill_level >= high_mark && $urandom_range(2) == 0) begin
            filling  = 1'b0;
            low_mark = ($urandom_range(9) < 6) ? 0 : $urandom_range(24);
         end else if (!filling && fill_level <= low_mark && $urandom_range(2) == 0) begin
            filling   = 1'b1;
            high_mark = ($urandom_range(9) < 6) ? mhpq_pkg::CAPACITY_DEF
                                                : $urandom_range(mhpq_pkg::CAPACITY_DEF - 1, 8);
         end
         issue(pick_mode(filling), pick_value());
      end
      start <= 1'b0;

      // one edge so the last item shows up in the outstanding count
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
